// ===== sv/csvt_pkg.sv =====
// Shared types and constants for the CSV byte tokenizer.
// Used by every module of the block; depends on nothing.
package csvt_pkg;

  localparam int unsigned MAX_COLUMNS_DEF   = 256;
  localparam int unsigned LINE_LEN_BITS_DEF = 24;
  localparam int unsigned QUEUE_DEPTH       = 2;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_DELIMITER = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_QUOTE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ESCAPE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LINE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_COL   = 3'd4;

  localparam logic [7:0]  DELIMITER_RST = 8'd44;
  localparam logic [7:0]  QUOTE_RST     = 8'd34;
  localparam logic [7:0]  ESCAPE_RST    = 8'd34;
  localparam logic [23:0] MAX_LINE_RST  = 24'd2097152;

  localparam logic [7:0] BYTE_BOM0 = 8'hEF;
  localparam logic [7:0] BYTE_BOM1 = 8'hBB;
  localparam logic [7:0] BYTE_BOM2 = 8'hBF;
  localparam logic [7:0] BYTE_CR   = 8'h0D;
  localparam logic [7:0] BYTE_LF   = 8'h0A;
  localparam logic [7:0] BYTE_NUL  = 8'h00;

  localparam logic [2:0] ERR_NONE        = 3'd0;
  localparam logic [2:0] ERR_AFTER_QUOTE = 3'd1;
  localparam logic [2:0] ERR_ESCAPE      = 3'd2;
  localparam logic [2:0] ERR_UNTERM      = 3'd3;
  localparam logic [2:0] ERR_LINE_LEN    = 3'd4;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [7:0] value_byte;
    logic       value_valid;
    logic       escape_mark;
    logic       field_end;
    logic       row_end;
    logic [7:0] column_index;
    logic       quoted_field;
    logic       newline_crlf;
    logic [2:0] error_code;
    logic       done_res;
  } out_item_t;

  // One classified byte as it travels from the front to the back.
  typedef struct packed {
    logic [7:0] byte_val;
    logic       eoi;
    logic       is_quote;
    logic       is_delim;
    logic       is_esc;      // escape byte with escaping enabled
    logic       is_esc_raw;  // equal to escape_char, whatever its value
    logic       is_cr;
    logic       is_lf;
    logic       is_bom0;
    logic       is_bom1;
    logic       is_bom2;
  } tok_t;

  typedef struct packed {
    logic [23:0] max_line_bytes;
    logic        one_column;
    logic        esc_is_quote;
  } cfg_t;

endpackage

// ===== sv/csvt_front.sv =====
// Front end: configuration registers and byte classification.
// Depends on csvt_pkg; feeds csvt_queue.
module csvt_front import csvt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_item,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  q_full,
  output logic                  q_push,
  output tok_t                  q_tok,
  output cfg_t                  cfg
);

  logic [7:0]  delim_r;
  logic [7:0]  quote_r;
  logic [7:0]  escape_r;
  logic [23:0] max_line_r;
  logic        one_col_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delim_r    <= DELIMITER_RST;
      quote_r    <= QUOTE_RST;
      escape_r   <= ESCAPE_RST;
      max_line_r <= MAX_LINE_RST;
      one_col_r  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DELIMITER: delim_r    <= cfg_data[7:0];
        REG_QUOTE:     quote_r    <= cfg_data[7:0];
        REG_ESCAPE:    escape_r   <= cfg_data[7:0];
        REG_MAX_LINE:  max_line_r <= cfg_data[23:0];
        REG_ONE_COL:   one_col_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign cfg.max_line_bytes = max_line_r;
  assign cfg.one_column     = one_col_r;
  assign cfg.esc_is_quote   = (escape_r == BYTE_NUL) || (escape_r == quote_r);

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_tok.byte_val   = in_item.in_byte;
    q_tok.eoi        = in_item.end_of_input;
    q_tok.is_quote   = in_item.in_byte == quote_r;
    q_tok.is_delim   = in_item.in_byte == delim_r;
    q_tok.is_esc_raw = in_item.in_byte == escape_r;
    q_tok.is_esc     = (escape_r != BYTE_NUL) && (in_item.in_byte == escape_r);
    q_tok.is_cr      = in_item.in_byte == BYTE_CR;
    q_tok.is_lf      = in_item.in_byte == BYTE_LF;
    q_tok.is_bom0    = in_item.in_byte == BYTE_BOM0;
    q_tok.is_bom1    = in_item.in_byte == BYTE_BOM1;
    q_tok.is_bom2    = in_item.in_byte == BYTE_BOM2;
  end

endmodule

// ===== sv/csvt_queue.sv =====
// Short queue of classified bytes between the front and the back.
// Depends on csvt_pkg.
module csvt_queue import csvt_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  tok_t push_tok,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output tok_t head_tok
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH < 2) ? 1 : $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  tok_t             mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full       = count_r == CNT_W'(QUEUE_DEPTH);
  assign head_valid = count_r != '0;
  assign head_tok   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ===== sv/csvt_back.sv =====
// Back end: the CSV parse state machine and the output register.
// Depends on csvt_pkg; takes classified bytes from csvt_queue.
module csvt_back import csvt_pkg::*; #(
  parameter int unsigned MAX_COLUMNS   = MAX_COLUMNS_DEF,
  parameter int unsigned LINE_LEN_BITS = LINE_LEN_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      head_valid,
  input  tok_t      head_tok,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  localparam int unsigned COL_LIMIT = ((MAX_COLUMNS - 1) < 255) ? (MAX_COLUMNS - 1) : 255;
  localparam int unsigned COL_W     = (COL_LIMIT < 2) ? 1 : $clog2(COL_LIMIT + 1);
  localparam int unsigned CMP_W     = (LINE_LEN_BITS > 24) ? LINE_LEN_BITS : 24;

  typedef enum logic [7:0] {
    ST_START = 8'b0000_0001,
    ST_PLAIN = 8'b0000_0010,
    ST_INQ   = 8'b0000_0100,
    ST_UNQ   = 8'b0000_1000,
    ST_ESC   = 8'b0001_0000,
    ST_CR    = 8'b0010_0000,
    ST_SKIP  = 8'b0100_0000,
    ST_HALT  = 8'b1000_0000
  } state_t;

  state_t                   st_r, st_nxt;
  logic [COL_W-1:0]         col_r, col_nxt;
  logic [LINE_LEN_BITS-1:0] len_r, len_nxt;
  logic [1:0]               bom_r, bom_nxt;
  logic                     fq_r, fq_nxt;
  logic                     out_valid_r;
  out_item_t                out_r;
  out_item_t                res;

  always_comb begin
    state_t                   ps;
    state_t                   after_row;
    logic                     nl;
    logic                     row_byte;
    logic                     consumed;
    logic                     plain_path;
    logic [LINE_LEN_BITS-1:0] len_n;
    logic [COL_W-1:0]         col_inc;

    res        = '0;
    st_nxt     = st_r;
    col_nxt    = col_r;
    len_nxt    = len_r;
    bom_nxt    = bom_r;
    fq_nxt     = fq_r;
    consumed   = 1'b0;
    plain_path = 1'b0;
    row_byte   = 1'b0;
    ps         = st_r;
    nl         = head_tok.is_cr || head_tok.is_lf;
    after_row  = cfg.one_column ? ST_START : ST_SKIP;
    len_n      = (len_r != '1) ? len_r + 1'b1 : len_r;
    col_inc    = (col_r < COL_W'(COL_LIMIT)) ? col_r + 1'b1 : col_r;

    if (st_r == ST_HALT) begin
      res.done_res = 1'b1;
    end else begin
      res.column_index = 8'(col_r);
      if (head_tok.eoi) begin
        if (st_r == ST_INQ) begin
          res.error_code = ERR_UNTERM;
          res.done_res   = 1'b1;
          st_nxt         = ST_HALT;
        end else if (st_r == ST_ESC) begin
          res.error_code = ERR_ESCAPE;
          res.done_res   = 1'b1;
          st_nxt         = ST_HALT;
        end else begin
          // A pending field or a trailing delimiter closes the last row.
          if ((st_r == ST_START && col_r != '0) || st_r == ST_PLAIN || st_r == ST_UNQ) begin
            res.field_end    = 1'b1;
            res.row_end      = 1'b1;
            res.quoted_field = fq_r;
          end
          bom_nxt      = 2'd3;
          st_nxt       = ST_HALT;
          res.done_res = 1'b1;
        end
      end else begin
        // Byte order mark: swallowed only while it matches from the very start.
        unique case (bom_r)
          2'd0: begin
            bom_nxt  = head_tok.is_bom0 ? 2'd1 : 2'd3;
            consumed = head_tok.is_bom0;
          end
          2'd1: begin
            bom_nxt  = head_tok.is_bom1 ? 2'd2 : 2'd3;
            consumed = head_tok.is_bom1;
          end
          2'd2: begin
            bom_nxt  = 2'd3;
            consumed = head_tok.is_bom2;
          end
          default: ;
        endcase

        if (!consumed && ps == ST_CR) begin
          if (head_tok.is_lf) begin
            res.newline_crlf = 1'b1;
            st_nxt           = after_row;
            consumed         = 1'b1;
          end else begin
            ps = after_row;
          end
        end
        if (!consumed && ps == ST_SKIP) begin
          if (nl) begin
            st_nxt   = ST_SKIP;
            consumed = 1'b1;
          end else begin
            ps = ST_START;
          end
        end

        if (!consumed) begin
          st_nxt = ps;
          if (ps == ST_START && !head_tok.is_quote && !head_tok.is_delim && nl) begin
            row_byte = 1'b1;
          end
          if (ps == ST_PLAIN && !head_tok.is_delim && nl) begin
            row_byte = 1'b1;
          end
          if (ps == ST_UNQ && !(head_tok.is_quote && cfg.esc_is_quote) &&
              !head_tok.is_delim && nl) begin
            row_byte = 1'b1;
          end

          if (!row_byte && (CMP_W'(len_n) > CMP_W'(cfg.max_line_bytes))) begin
            res.error_code = ERR_LINE_LEN;
            res.done_res   = 1'b1;
            st_nxt         = ST_HALT;
          end else begin
            if (!row_byte) begin
              len_nxt = len_n;
            end
            unique case (ps)
              ST_START: begin
                if (head_tok.is_quote) begin
                  fq_nxt           = 1'b1;
                  st_nxt           = ST_INQ;
                  res.quoted_field = 1'b1;
                end else begin
                  plain_path = 1'b1;
                end
              end
              ST_PLAIN: begin
                plain_path = 1'b1;
              end
              ST_INQ: begin
                res.quoted_field = fq_r;
                if (head_tok.is_quote) begin
                  st_nxt = ST_UNQ;
                end else begin
                  res.value_byte  = head_tok.byte_val;
                  res.value_valid = 1'b1;
                  res.escape_mark = head_tok.is_esc;
                  if (head_tok.is_esc) begin
                    st_nxt = ST_ESC;
                  end
                end
              end
              ST_UNQ: begin
                if (head_tok.is_quote && cfg.esc_is_quote) begin
                  // Doubled quote: one quote byte of content.
                  res.value_byte   = head_tok.byte_val;
                  res.value_valid  = 1'b1;
                  res.quoted_field = fq_r;
                  st_nxt           = ST_INQ;
                end else if (head_tok.is_delim || nl) begin
                  plain_path = 1'b1;
                end else begin
                  res.quoted_field = fq_r;
                  res.error_code   = ERR_AFTER_QUOTE;
                  res.done_res     = 1'b1;
                  st_nxt           = ST_HALT;
                end
              end
              default: begin
                // Byte after an escape byte must be the quote or the escape byte.
                res.quoted_field = fq_r;
                if (!head_tok.is_quote && !head_tok.is_esc_raw) begin
                  res.error_code = ERR_ESCAPE;
                  res.done_res   = 1'b1;
                  st_nxt         = ST_HALT;
                end else begin
                  res.value_byte  = head_tok.byte_val;
                  res.value_valid = 1'b1;
                  st_nxt          = ST_INQ;
                end
              end
            endcase

            if (plain_path) begin
              if (head_tok.is_delim) begin
                res.field_end    = 1'b1;
                res.quoted_field = fq_r;
                col_nxt          = col_inc;
                fq_nxt           = 1'b0;
                st_nxt           = ST_START;
              end else if (nl) begin
                res.field_end    = 1'b1;
                res.row_end      = 1'b1;
                res.quoted_field = fq_r;
                col_nxt          = '0;
                len_nxt          = '0;
                fq_nxt           = 1'b0;
                st_nxt           = head_tok.is_cr ? ST_CR : after_row;
              end else begin
                res.value_byte   = head_tok.byte_val;
                res.value_valid  = 1'b1;
                res.quoted_field = fq_r;
                st_nxt           = ST_PLAIN;
              end
            end
          end
        end
      end
    end
  end

  assign pop = head_valid && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_START;
      col_r       <= '0;
      len_r       <= '0;
      bom_r       <= 2'd0;
      fq_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        st_r        <= st_nxt;
        col_r       <= col_nxt;
        len_r       <= len_nxt;
        bom_r       <= bom_nxt;
        fq_r        <= fq_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

// ===== sv/csv_byte_tokenizer.sv =====
// CSV byte tokenizer, top level: front (config and classify), queue, back (parser).
// Each accepted byte is written into the queue, then parsed from the queue head into the output register.
// Throughput: one byte per clock while the output is not stalled; the back end parses each byte combinationally.
// A full two-entry queue stalls the input; the output register holds a stalled beat.
// Reset (rst_n low, synchronous) restores the register defaults and the parse state.
// Depends on csvt_pkg, csvt_front, csvt_queue and csvt_back.
module csv_byte_tokenizer import csvt_pkg::*; #(
  parameter int unsigned MAX_COLUMNS   = MAX_COLUMNS_DEF,
  parameter int unsigned LINE_LEN_BITS = LINE_LEN_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_item,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t cfg;
  tok_t push_tok;
  tok_t head_tok;
  logic q_push;
  logic q_full;
  logic q_pop;
  logic head_valid;

  csvt_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_tok     (push_tok),
    .cfg       (cfg)
  );

  csvt_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_tok   (push_tok),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_tok   (head_tok)
  );

  csvt_back #(
    .MAX_COLUMNS   (MAX_COLUMNS),
    .LINE_LEN_BITS (LINE_LEN_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head_tok   (head_tok),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item)
  );

endmodule

// ===== test/csv_token_checker.sv =====
// Checker for the CSV byte tokenizer: watches the input, result and register channels.
// Predicts one result beat per accepted input beat and compares in order; uses csvt_pkg.
`timescale 1ns / 1ps

module csv_token_checker import csvt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  in_item_t              in_item,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  out_item_t             out_item,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatches,
  output int                    pending_beats
);

  typedef enum logic [2:0] {
    PS_START, PS_PLAIN, PS_IN_QUOTES, PS_AFTER_QUOTE,
    PS_AFTER_ESC, PS_AFTER_CR, PS_SKIP_EMPTY, PS_HALTED
  } parse_state_t;

  localparam int COL_CAP = (MAX_COLUMNS_DEF - 1 < 255) ? MAX_COLUMNS_DEF - 1 : 255;

  logic [7:0]   cfg_delim, cfg_quote, cfg_esc;
  logic [23:0]  cfg_max;
  logic         cfg_one;

  parse_state_t pstate;
  logic [7:0]   col_count;
  logic [23:0]  len_count;
  logic [1:0]   bom_stage;
  logic         quoted_now;
  logic         nonempty_now;

  out_item_t    expected_beats[$];
  out_item_t    want;

  function automatic void clear_parser();
    cfg_delim    = DELIMITER_RST;
    cfg_quote    = QUOTE_RST;
    cfg_esc      = ESCAPE_RST;
    cfg_max      = MAX_LINE_RST;
    cfg_one      = 1'b0;
    pstate       = PS_START;
    col_count    = '0;
    len_count    = '0;
    bom_stage    = '0;
    quoted_now   = 1'b0;
    nonempty_now = 1'b0;
  endfunction

  function automatic void emit_value(inout out_item_t r, input logic [7:0] b, input logic mark);
    r.value_byte   = b;
    r.value_valid  = 1'b1;
    r.escape_mark  = mark;
    r.quoted_field = quoted_now;
    nonempty_now   = 1'b1;
  endfunction

  function automatic void close_field(inout out_item_t r);
    r.field_end    = 1'b1;
    r.quoted_field = quoted_now;
    if (col_count < COL_CAP) col_count = col_count + 1'b1;
    quoted_now   = 1'b0;
    nonempty_now = 1'b0;
    pstate       = PS_START;
  endfunction

  function automatic void close_row(inout out_item_t r, input logic [7:0] b);
    r.field_end    = 1'b1;
    r.row_end      = 1'b1;
    r.quoted_field = quoted_now;
    col_count    = '0;
    len_count    = '0;
    quoted_now   = 1'b0;
    nonempty_now = 1'b0;
    if (b == BYTE_CR) pstate = PS_AFTER_CR;
    else pstate = cfg_one ? PS_START : PS_SKIP_EMPTY;
  endfunction

  function automatic void raise_error(inout out_item_t r, input logic [2:0] code);
    r.error_code = code;
    r.done_res   = 1'b1;
    pstate       = PS_HALTED;
  endfunction

  // Advances the parser by one input beat and returns the result beat it yields.
  function automatic out_item_t tokenize_byte(in_item_t it);
    out_item_t    r;
    logic [7:0]   b;
    logic         nl, doubling, row_byte;
    parse_state_t s;
    logic [23:0]  n;
    r = '0;
    b = it.in_byte;
    if (pstate == PS_HALTED) begin
      r.done_res = 1'b1;
      return r;
    end
    r.column_index = col_count;

    if (it.end_of_input) begin
      if (pstate == PS_IN_QUOTES) begin
        raise_error(r, ERR_UNTERM);
        return r;
      end
      if (pstate == PS_AFTER_ESC) begin
        raise_error(r, ERR_ESCAPE);
        return r;
      end
      if ((pstate == PS_START && col_count != 0) || pstate == PS_PLAIN ||
          pstate == PS_AFTER_QUOTE) begin
        r.field_end    = 1'b1;
        r.row_end      = 1'b1;
        r.quoted_field = quoted_now;
      end
      bom_stage  = 2'd3;
      pstate     = PS_HALTED;
      r.done_res = 1'b1;
      return r;
    end

    // A byte order mark is only looked for at the very start of the text.
    if (bom_stage == 2'd0) begin
      if (b == BYTE_BOM0) begin
        bom_stage = 2'd1;
        return r;
      end
      bom_stage = 2'd3;
    end else if (bom_stage == 2'd1) begin
      if (b == BYTE_BOM1) begin
        bom_stage = 2'd2;
        return r;
      end
      bom_stage = 2'd3;
    end else if (bom_stage == 2'd2) begin
      bom_stage = 2'd3;
      if (b == BYTE_BOM2) return r;
    end

    nl = (b == BYTE_CR || b == BYTE_LF);
    s  = pstate;
    if (s == PS_AFTER_CR) begin
      if (b == BYTE_LF) begin
        r.newline_crlf = 1'b1;
        pstate = cfg_one ? PS_START : PS_SKIP_EMPTY;
        return r;
      end
      s = cfg_one ? PS_START : PS_SKIP_EMPTY;
    end
    if (s == PS_SKIP_EMPTY) begin
      if (nl) begin
        pstate = PS_SKIP_EMPTY;
        return r;
      end
      s = PS_START;
    end
    pstate = s;

    doubling = (cfg_esc == BYTE_NUL || cfg_esc == cfg_quote);
    row_byte = 1'b0;
    if (s == PS_START && b != cfg_quote && b != cfg_delim && nl) row_byte = 1'b1;
    if (s == PS_PLAIN && b != cfg_delim && nl) row_byte = 1'b1;
    if (s == PS_AFTER_QUOTE && !(b == cfg_quote && doubling) && b != cfg_delim && nl)
      row_byte = 1'b1;

    // The newline that ends a row is not counted in its line's length.
    if (!row_byte) begin
      n = len_count;
      if (n != '1) n = n + 1'b1;
      if (n > cfg_max) begin
        raise_error(r, ERR_LINE_LEN);
        return r;
      end
      len_count = n;
    end

    case (s)
      PS_START, PS_PLAIN: begin
        if (s == PS_START && b == cfg_quote) begin
          quoted_now     = 1'b1;
          pstate         = PS_IN_QUOTES;
          r.quoted_field = 1'b1;
        end else if (b == cfg_delim) begin
          close_field(r);
        end else if (nl) begin
          close_row(r, b);
        end else begin
          emit_value(r, b, 1'b0);
          pstate = PS_PLAIN;
        end
      end
      PS_IN_QUOTES: begin
        r.quoted_field = quoted_now;
        if (b == cfg_quote) begin
          pstate = PS_AFTER_QUOTE;
        end else if (cfg_esc != BYTE_NUL && b == cfg_esc) begin
          emit_value(r, b, 1'b1);
          pstate = PS_AFTER_ESC;
        end else begin
          emit_value(r, b, 1'b0);
        end
      end
      PS_AFTER_QUOTE: begin
        if (b == cfg_quote && doubling) begin
          emit_value(r, b, 1'b0);
          pstate = PS_IN_QUOTES;
        end else if (b == cfg_delim) begin
          close_field(r);
        end else if (nl) begin
          close_row(r, b);
        end else begin
          r.quoted_field = quoted_now;
          raise_error(r, ERR_AFTER_QUOTE);
        end
      end
      default: begin
        r.quoted_field = quoted_now;
        if (b != cfg_quote && b != cfg_esc) begin
          raise_error(r, ERR_ESCAPE);
        end else begin
          emit_value(r, b, 1'b0);
          pstate = PS_IN_QUOTES;
        end
      end
    endcase
    return r;
  endfunction

  function automatic void check_field(string name, logic [7:0] exp_v, logic [7:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t: %s expected %0h got %0h", $time, name, exp_v, got_v);
      mismatches++;
    end
  endfunction

  initial clear_parser();

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_parser();
      expected_beats.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_beats.size() == 0) begin
          $display("%0t: result beat %h with none expected", $time, out_item);
          mismatches++;
        end else begin
          want = expected_beats.pop_front();
          check_field("value_byte", want.value_byte, out_item.value_byte);
          check_field("value_valid", want.value_valid, out_item.value_valid);
          check_field("escape_mark", want.escape_mark, out_item.escape_mark);
          check_field("field_end", want.field_end, out_item.field_end);
          check_field("row_end", want.row_end, out_item.row_end);
          check_field("column_index", want.column_index, out_item.column_index);
          check_field("quoted_field", want.quoted_field, out_item.quoted_field);
          check_field("newline_crlf", want.newline_crlf, out_item.newline_crlf);
          check_field("error_code", want.error_code, out_item.error_code);
          check_field("done_res", want.done_res, out_item.done_res);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_DELIMITER: cfg_delim = cfg_data[7:0];
          REG_QUOTE:     cfg_quote = cfg_data[7:0];
          REG_ESCAPE:    cfg_esc   = cfg_data[7:0];
          REG_MAX_LINE:  cfg_max   = cfg_data;
          REG_ONE_COL:   cfg_one   = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        expected_beats = {expected_beats, tokenize_byte(in_item)};
      end
    end
    pending_beats = expected_beats.size();
  end

endmodule

// ===== test/testbench.sv =====
// Top of the CSV tokenizer test: clock, reset, register setup, byte stimulus and verdict.
// Instantiates csv_byte_tokenizer and csv_token_checker; uses csvt_pkg.
`timescale 1ns / 1ps

module testbench;
  import csvt_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 60;

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_item_t              in_item   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_item;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  int mismatches;
  int pending_beats;

  logic in_fire  = 1'b0;
  logic cfg_fire = 1'b0;
  int   sent      = 0;
  int   gap_pct   = 0;
  int   stall_pct = 0;
  int   hold_req  = 0;
  int   hold_done = 0;
  int   cycle_cnt;

  // Settings the byte generator keeps its text legal under.
  logic [7:0] g_delim = DELIMITER_RST;
  logic [7:0] g_quote = QUOTE_RST;
  logic [7:0] g_esc   = ESCAPE_RST;
  int         g_max   = int'(MAX_LINE_RST);

  logic [7:0] line_q[$];
  int         room;

  csv_byte_tokenizer u_top (
    .clk, .rst_n, .in_valid, .in_stall, .in_item, .out_valid, .out_stall, .out_item,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  csv_token_checker u_checker (
    .clk, .rst_n, .in_valid, .in_stall, .in_item, .out_valid, .out_stall, .out_item,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .mismatches, .pending_beats
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    in_fire  <= in_valid && !in_stall;
    cfg_fire <= cfg_valid && cfg_ready;
  end

  // Receiver: random stalls, plus a long hold-off whenever one is requested.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_done != hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_done++;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  task automatic send_item(in_item_t it);
    if (sent < 530) begin
      gap_pct   = 14;
      stall_pct = 81;
    end else if (sent < 1060) begin
      gap_pct   = 81;
      stall_pct = 14;
    end else begin
      gap_pct   = 0;
      stall_pct = 0;
    end
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(negedge clk); while (!in_fire);
    sent++;
  endtask

  task automatic send_line();
    foreach (line_q[i]) send_item('{in_byte: line_q[i], end_of_input: 1'b0});
    line_q.delete();
  endtask

  task automatic send_end();
    send_item('{in_byte: 8'($urandom_range(255)), end_of_input: 1'b1});
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_beats != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic apply_config(input logic [7:0] d, q, e, input logic [23:0] m,
                              input logic o);
    logic [CFG_IDX_W-1:0]  idx [5] = '{REG_DELIMITER, REG_QUOTE, REG_ESCAPE,
                                       REG_MAX_LINE, REG_ONE_COL};
    logic [CFG_DATA_W-1:0] vals [5];
    vals = '{24'(d), 24'(q), 24'(e), m, 24'(o)};
    for (int i = 0; i < 5; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= vals[i];
      do @(negedge clk); while (!cfg_fire);
    end
    cfg_valid <= 1'b0;
    g_delim = d;
    g_quote = q;
    g_esc   = e;
    g_max   = int'(m);
  endtask

  function automatic void append_byte(logic [7:0] b);
    line_q = {line_q, b};
  endfunction

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) append_byte(s[i]);
  endfunction

  function automatic bit quote_doubling();
    return g_esc == BYTE_NUL || g_esc == g_quote;
  endfunction

  function automatic logic [7:0] plain_byte(bit first);
    logic [7:0] b;
    do b = 8'($urandom_range(255));
    while (b == g_delim || b == BYTE_CR || b == BYTE_LF || (first && b == g_quote));
    return b;
  endfunction

  function automatic logic [7:0] quoted_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255));
    while (b == g_quote || (g_esc != BYTE_NUL && b == g_esc));
    return b;
  endfunction

  function automatic void add_newline();
    case ($urandom_range(2))
      0: append_byte(BYTE_LF);
      1: append_byte(BYTE_CR);
      default: begin
        append_byte(BYTE_CR);
        append_byte(BYTE_LF);
      end
    endcase
  endfunction

  // Appends one legal field that fits in the bytes left on the line.
  function automatic void add_field();
    int kind, n, pick;
    kind = $urandom_range(9);
    if (room >= 2 && kind < 4) begin
      append_byte(g_quote);
      room -= 2;
      n = $urandom_range(0, 6);
      for (int i = 0; i < n && room > 0; i++) begin
        pick = $urandom_range(5);
        if (pick == 0 && room >= 2 && quote_doubling()) begin
          append_byte(g_quote);
          append_byte(g_quote);
          room -= 2;
        end else if (pick == 1 && room >= 2 && !quote_doubling()) begin
          append_byte(g_esc);
          append_byte($urandom_range(1) ? g_quote : g_esc);
          room -= 2;
        end else begin
          append_byte(quoted_byte());
          room--;
        end
      end
      append_byte(g_quote);
    end else if (room >= 1 && kind < 8) begin
      n = $urandom_range(1, (room < 8) ? room : 8);
      append_byte(plain_byte(1'b1));
      for (int i = 1; i < n; i++) append_byte(plain_byte(1'b0));
      room -= n;
    end
  endfunction

  function automatic void make_row();
    int nf;
    room = (g_max < 400) ? g_max : 400;
    if ($urandom_range(7) == 0) add_newline();
    nf = $urandom_range(1, 5);
    for (int i = 0; i < nf; i++) begin
      if (i > 0) begin
        if (room == 0) break;
        append_byte(g_delim);
        room--;
      end
      add_field();
    end
    add_newline();
  endfunction

  task automatic run_rows(int n_items);
    int start;
    start = sent;
    while (sent - start < n_items) begin
      make_row();
      send_line();
    end
  endtask

  initial begin
    logic [7:0] d, q, e;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // Start of text: complete, broken or missing byte order mark.
    case ($urandom_range(3))
      0: line_q = '{BYTE_BOM0, BYTE_BOM1, BYTE_BOM2};
      1: line_q = '{BYTE_BOM0};
      2: line_q = '{BYTE_BOM0, BYTE_BOM1};
      default: ;
    endcase
    push_text("a,\"b\"\"c\",");
    append_byte(BYTE_CR);
    push_text("\n\n\"x\ny\",");
    append_byte(8'hFF);
    append_byte(BYTE_NUL);
    append_byte(BYTE_CR);
    append_byte(BYTE_BOM0);
    append_byte(BYTE_BOM1);
    append_byte(BYTE_BOM2);
    push_text("\n\"\",\"\"\n");
    send_line();

    // A row far wider than the column counter can hold.
    append_byte(plain_byte(1'b1));
    repeat (270) append_byte(g_delim);
    append_byte(plain_byte(1'b0));
    append_byte(BYTE_LF);
    send_line();
    run_rows(150);

    wait_idle();
    apply_config(8'h00, 8'hFF, 8'h5C, 24'hFFFFFF, 1'b1);
    line_q = '{8'hFF, 8'h5C, 8'hFF, 8'h5C, 8'h5C, 8'h71, 8'hFF, 8'h00, 8'h72, BYTE_LF};
    send_line();
    hold_req++;
    run_rows(250);

    wait_idle();
    apply_config(8'hFF, 8'h27, BYTE_NUL, 24'd1, 1'b0);
    run_rows(60);

    wait_idle();
    apply_config(8'h09, BYTE_NUL, 8'hFF, 24'd24, 1'b1);
    run_rows(250);

    wait_idle();
    apply_config(8'h3B, 8'h22, 8'h22, 24'd60, 1'b0);
    hold_req++;
    run_rows(250);

    wait_idle();
    do d = 8'($urandom_range(255)); while (d == BYTE_CR || d == BYTE_LF);
    do q = 8'($urandom_range(255)); while (q == BYTE_CR || q == BYTE_LF || q == d);
    case ($urandom_range(2))
      0: e = BYTE_NUL;
      1: e = q;
      default: begin
        do e = 8'($urandom_range(255));
        while (e == BYTE_CR || e == BYTE_LF || e == d || e == q || e == BYTE_NUL);
      end
    endcase
    apply_config(d, q, e, 24'($urandom_range(8, 300)), 1'($urandom_range(1)));
    run_rows(250);

    // Closing line: a clean end or one of the errors, then beats into the halted block.
    wait_idle();
    apply_config(",", "\"", "\\", 24'd8, 1'b0);
    case ($urandom_range(7))
      0: push_text("ab");
      1: push_text("a,");
      2: push_text("\"x");
      3: push_text("\"a\"b");
      4: push_text("\"\\x");
      5: push_text("\"\\");
      6: push_text("abcdefghi");
      default: push_text("\n");
    endcase
    send_line();
    send_end();
    repeat (3) append_byte(8'($urandom_range(255)));
    send_line();
    send_end();

    wait_idle();
    repeat (8) @(negedge clk);
    if (mismatches == 0 && pending_beats == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
